### hw/rtl/tts_pkg.sv
// Package for the tick task scheduler table: command and result transaction
// types, slot entry layout, kind codes and default sizing.
// No dependencies.
package tts_pkg;

	localparam int MAX_TASKS_DEF = 16;

	localparam logic [2:0] KIND_TICK     = 3'd0;
	localparam logic [2:0] KIND_ADD      = 3'd1;
	localparam logic [2:0] KIND_DELETE   = 3'd2;
	localparam logic [2:0] KIND_PAUSE    = 3'd3;
	localparam logic [2:0] KIND_RESUME   = 3'd4;
	localparam logic [2:0] KIND_DISPATCH = 3'd5;

	localparam logic [2:0] RK_ACK   = 3'd0;
	localparam logic [2:0] RK_ADDED = 3'd1;
	localparam logic [2:0] RK_FULL  = 3'd2;
	localparam logic [2:0] RK_RUN   = 3'd3;
	localparam logic [2:0] RK_DONE  = 3'd4;

	localparam logic [7:0] PEND_MAX = 8'hFF;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] task_handle;
		logic [15:0] start_delay;
		logic [15:0] period;
		logic [3:0]  slot;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [4:0]  out_slot;
		logic [31:0] out_handle;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] handle;
		logic [15:0] delay;
		logic [15:0] period;
		logic [7:0]  pending;
	} slot_entry_t;

endpackage

### hw/rtl/tts_mem.sv
// Slot entry memory: one write port, one read port, registered read data.
// Depends on tts_pkg for the entry type.
module tts_mem #(
	parameter int DEPTH = tts_pkg::MAX_TASKS_DEF,
	parameter int AW    = 4
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  tts_pkg::slot_entry_t  wdata,
	input  logic [AW-1:0]         raddr,
	output tts_pkg::slot_entry_t  rdata
);
	import tts_pkg::*;

	slot_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/tick_task_scheduler_table_core.sv
// Top level of the tick task scheduler table: command FSM, slot scan pipeline,
// valid and pause bits. Depends on tts_pkg and tts_mem.
//
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low. Results appear on rsp for exactly one cycle each, marked by rsp_valid;
//   the receiver cannot stall them.
//   Delete, pause, resume and unknown kinds never raise busy: the ack comes in
//   the cycle after the command, and a new command can follow every cycle.
//   Tick, add and dispatch walk the slot memory one entry per cycle through a
//   read stage and a modify/write stage (one read port, one write port).
//   Tick: the ack follows the update of the last slot.
//   Add: stops at the first free slot k, or reports full after the last slot.
//   Dispatch: run items stream out as slots qualify,
//   at most one per cycle, then the done item.
//   Reset clears the valid and pause bits at once; an entry whose valid bit is
//   clear reads as an empty slot, so no clearing pass is needed.
module tick_task_scheduler_table_core #(
	parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tts_pkg::cmd_t cmd,
	output logic          rsp_valid,
	output tts_pkg::rsp_t rsp
);
	import tts_pkg::*;

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam logic [IW-1:0] LAST_IX = IW'(MAX_TASKS - 1);
	localparam logic [6:0] MAX_W = 7'(MAX_TASKS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [IW-1:0]     idx_q;
	logic              iss_q;
	logic              v_s1;
	logic [IW-1:0]     idx_s1;
	logic              last_s1;
	logic [MAX_TASKS-1:0] valid_q;
	logic [MAX_TASKS-1:0] paused_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	slot_entry_t       rd_ent;
	slot_entry_t       ent;
	slot_entry_t       wr_ent;
	logic              we;
	logic              clr_v;
	logic              emit;
	rsp_t              emit_rsp;
	rsp_t              fix_rsp;
	logic              fin;
	logic              to_done;
	logic              occ;
	logic              accept;
	logic              scan_kind;
	logic              slot_ok;
	logic [6:0]        slot_w;
	logic [IW-1:0]     slot_ix;
	logic [6:0]        idx_w;

	tts_mem #(
		.DEPTH (MAX_TASKS),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (idx_s1),
		.wdata (wr_ent),
		.raddr (idx_q),
		.rdata (rd_ent)
	);

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign scan_kind = (cmd.kind == KIND_TICK) || (cmd.kind == KIND_ADD) ||
	                   (cmd.kind == KIND_DISPATCH);
	assign slot_w    = {3'b000, cmd.slot};
	assign slot_ix   = slot_w[IW-1:0];
	assign slot_ok   = (slot_w < MAX_W);
	assign idx_w     = 7'(idx_s1);

	assign ent = valid_q[idx_s1] ? rd_ent : '0;
	assign occ = (ent.handle != 32'd0);

	always_comb begin
		we       = 1'b0;
		wr_ent   = ent;
		clr_v    = 1'b0;
		emit     = 1'b0;
		emit_rsp = '0;
		fin      = 1'b0;
		to_done  = 1'b0;
		if (state_q == ST_SCAN && v_s1) begin
			case (cmd_q.kind)
				KIND_TICK: begin
					if (occ) begin
						we = 1'b1;
						if (ent.delay == 16'd0) begin
							if (ent.pending != PEND_MAX) begin
								wr_ent.pending = ent.pending + 8'd1;
							end
							if (ent.period != 16'd0) begin
								wr_ent.delay = ent.period;
							end
						end else begin
							wr_ent.delay = ent.delay - 16'd1;
						end
					end
					if (last_s1) begin
						emit = 1'b1;
						emit_rsp.result_kind = RK_ACK;
						emit_rsp.last = 1'b1;
						fin = 1'b1;
					end
				end
				KIND_ADD: begin
					if (!occ) begin
						we = 1'b1;
						wr_ent.handle  = cmd_q.task_handle;
						wr_ent.delay   = cmd_q.start_delay;
						wr_ent.period  = cmd_q.period;
						wr_ent.pending = 8'd0;
						emit = 1'b1;
						emit_rsp.result_kind = RK_ADDED;
						emit_rsp.out_slot = idx_w[4:0];
						emit_rsp.last = 1'b1;
						fin = 1'b1;
					end else if (last_s1) begin
						emit = 1'b1;
						emit_rsp.result_kind = RK_FULL;
						emit_rsp.out_slot = MAX_W[4:0];
						emit_rsp.last = 1'b1;
						fin = 1'b1;
					end
				end
				default: begin
					if (occ && ent.pending != 8'd0 && !paused_q[idx_s1]) begin
						emit = 1'b1;
						emit_rsp.result_kind = RK_RUN;
						emit_rsp.out_slot = idx_w[4:0];
						emit_rsp.out_handle = ent.handle;
						if (ent.period == 16'd0) begin
							clr_v = 1'b1;
						end else begin
							we = 1'b1;
							wr_ent.pending = ent.pending - 8'd1;
						end
					end
					if (last_s1) begin
						to_done = 1'b1;
					end
				end
			endcase
		end
	end

	// ack for commands that do not scan the slots, done item after a dispatch scan
	always_comb begin
		fix_rsp             = '0;
		fix_rsp.result_kind = (state_q == ST_DONE) ? RK_DONE : RK_ACK;
		fix_rsp.last        = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q   <= 1'b0;
			v_s1    <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					v_s1 <= 1'b0;
					if (accept && scan_kind) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						iss_q   <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (fin) begin
						state_q <= ST_IDLE;
						iss_q   <= 1'b0;
						v_s1    <= 1'b0;
					end else begin
						v_s1 <= iss_q;
						if (iss_q) begin
							if (idx_q == LAST_IX) begin
								iss_q <= 1'b0;
							end else begin
								idx_q <= idx_q + IW'(1);
							end
						end
						if (to_done) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		idx_s1  <= idx_q;
		last_s1 <= (idx_q == LAST_IX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			paused_q <= '0;
		end else begin
			if (we) begin
				valid_q[idx_s1] <= 1'b1;
			end else if (clr_v) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (accept && slot_ok) begin
				if (cmd.kind == KIND_DELETE) begin
					valid_q[slot_ix] <= 1'b0;
				end
				if (cmd.kind == KIND_PAUSE) begin
					paused_q[slot_ix] <= 1'b1;
				end
				if (cmd.kind == KIND_RESUME) begin
					paused_q[slot_ix] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= emit || (state_q == ST_DONE) || (accept && !scan_kind);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_rsp;
		end else begin
			rsp_q <= fix_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> (rsp_valid && rsp.result_kind == RK_DONE && rsp.last))
		else $error("done state without done item");

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_SCAN))
		else $error("read stage active outside scan");

	a_run_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> (rsp.result_kind == RK_RUN))
		else $error("non-final item that is not a run");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(we || clr_v) |-> (int'(idx_s1) < MAX_TASKS))
		else $error("slot write out of range");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && clr_v))
		else $error("write and free of one slot together");

endmodule
